@@ src/ntc_thermistor_temperature_defines.svh @@
// assertion macros for the thermistor converter checker
`ifndef NTC_THERMISTOR_TEMPERATURE_DEFINES_SVH
`define NTC_THERMISTOR_TEMPERATURE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define NTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ntc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define NTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ntc assertion failed");

`endif

@@ src/ntc_pkg.sv @@
// shared widths, operation codes, resistance table and temperature helpers
package ntc_pkg;

	// field widths
	localparam int ADC_W      = 12;
	localparam int SER_W      = 20;
	localparam int SCALED_W   = 24;
	localparam int DIVIDEND_W = 36;
	localparam int DIVISOR_W  = 21;
	localparam int REM_W      = 22;
	localparam int RES_W      = 22;
	localparam int TEMP_W     = 17;
	localparam int FLAG_W     = 2;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 6;
	localparam int INTERP_W   = 33;

	// divider pass lengths
	localparam int DIV1_STEPS = 36;
	localparam int DIV2_STEPS = 12;

	localparam int ROM_SIZE = 39;

	localparam logic [RES_W-1:0]         RES_MAX     = 22'h3FFFFF;
	localparam logic signed [TEMP_W-1:0] TOP_TEMP_Q8 = 17'sd38400;

	// range flag codes
	localparam logic [FLAG_W-1:0] FLAG_IN   = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_HOT  = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_COLD = 2'd2;

	// datapath operation codes
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_LOAD  = 4'd0;
	localparam logic [OP_W-1:0] OP_MUL   = 4'd1;
	localparam logic [OP_W-1:0] OP_DIV   = 4'd2;
	localparam logic [OP_W-1:0] OP_SAT   = 4'd3;
	localparam logic [OP_W-1:0] OP_SRCH  = 4'd4;
	localparam logic [OP_W-1:0] OP_CLASS = 4'd5;
	localparam logic [OP_W-1:0] OP_PREP  = 4'd6;
	localparam logic [OP_W-1:0] OP_FIN   = 4'd7;
	localparam logic [OP_W-1:0] OP_OUT   = 4'd8;
	localparam logic [OP_W-1:0] OP_FULL  = 4'd9;

	// sequencer to datapath control
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            in_ready;
		logic            in_accept;
		logic            out_load;
	} ctrl_t;

	// datapath to sequencer status
	typedef struct packed {
		logic adc_full;
		logic cnt_nz;
		logic srch_more;
		logic at_edge;
	} dp_stat_t;

	// thermistor resistance in tenths of an ohm, 150 C down to -40 C in 5 C steps
	function automatic logic [RES_W-1:0] ntc_rom(input logic [IDX_W-1:0] idx);
		logic [RES_W-1:0] r;
		unique case (idx)
			6'd0:    r = 22'd1861;
			6'd1:    r = 22'd2090;
			6'd2:    r = 22'd2354;
			6'd3:    r = 22'd2658;
			6'd4:    r = 22'd3010;
			6'd5:    r = 22'd3419;
			6'd6:    r = 22'd3896;
			6'd7:    r = 22'd4452;
			6'd8:    r = 22'd5106;
			6'd9:    r = 22'd5876;
			6'd10:   r = 22'd6786;
			6'd11:   r = 22'd7866;
			6'd12:   r = 22'd9154;
			6'd13:   r = 22'd10700;
			6'd14:   r = 22'd12550;
			6'd15:   r = 22'd14790;
			6'd16:   r = 22'd17520;
			6'd17:   r = 22'd20830;
			6'd18:   r = 22'd24880;
			6'd19:   r = 22'd29860;
			6'd20:   r = 22'd36020;
			6'd21:   r = 22'd43680;
			6'd22:   r = 22'd53260;
			6'd23:   r = 22'd65310;
			6'd24:   r = 22'd80570;
			6'd25:   r = 22'd100000;
			6'd26:   r = 22'd124920;
			6'd27:   r = 22'd157110;
			6'd28:   r = 22'd198990;
			6'd29:   r = 22'd253910;
			6'd30:   r = 22'd326500;
			6'd31:   r = 22'd423260;
			6'd32:   r = 22'd553260;
			6'd33:   r = 22'd729510;
			6'd34:   r = 22'd970720;
			6'd35:   r = 22'd1304100;
			6'd36:   r = 22'd1769600;
			6'd37:   r = 22'd2426600;
			6'd38:   r = 22'd3364500;
			default: r = '0;
		endcase
		return r;
	endfunction

	// temperature of a table entry in q8: 38400 - 1280 * idx
	function automatic logic signed [TEMP_W-1:0] temp_q8_at(input logic [IDX_W-1:0] idx);
		logic [TEMP_W-1:0] off;
		off = TEMP_W'({idx, 10'b0}) + TEMP_W'({idx, 8'b0});
		return TOP_TEMP_Q8 - $signed(off);
	endfunction

endpackage

@@ src/ntc_seq.sv @@
// microcode sequencer: step counter, program table and branch conditions
module ntc_seq import ntc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_busy,
	input  dp_stat_t dp_stat,
	output ctrl_t    ctrl
);

	localparam int PC_W   = 4;
	localparam int COND_W = 3;

	// branch conditions
	localparam logic [COND_W-1:0] C_ALWAYS  = 3'd0;
	localparam logic [COND_W-1:0] C_NOIN    = 3'd1;
	localparam logic [COND_W-1:0] C_FULL    = 3'd2;
	localparam logic [COND_W-1:0] C_CNT     = 3'd3;
	localparam logic [COND_W-1:0] C_SRCH    = 3'd4;
	localparam logic [COND_W-1:0] C_EDGE    = 3'd5;
	localparam logic [COND_W-1:0] C_OUTBUSY = 3'd6;

	// program addresses
	localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] ST_MUL   = 4'd1;
	localparam logic [PC_W-1:0] ST_DIV1  = 4'd2;
	localparam logic [PC_W-1:0] ST_SAT   = 4'd3;
	localparam logic [PC_W-1:0] ST_SRCH  = 4'd4;
	localparam logic [PC_W-1:0] ST_CLASS = 4'd5;
	localparam logic [PC_W-1:0] ST_PREP  = 4'd6;
	localparam logic [PC_W-1:0] ST_DIV2  = 4'd7;
	localparam logic [PC_W-1:0] ST_FIN   = 4'd8;
	localparam logic [PC_W-1:0] ST_OUT   = 4'd9;
	localparam logic [PC_W-1:0] ST_FULL  = 4'd10;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   jmp;
		logic [PC_W-1:0]   nxt;
	} ucode_t;

	// control store: taken branch goes to jmp, otherwise nxt
	function automatic ucode_t prog_word(input logic [PC_W-1:0] a);
		ucode_t w;
		unique case (a)
			ST_IDLE:  w = '{OP_LOAD,  C_NOIN,    ST_IDLE,  ST_MUL};
			ST_MUL:   w = '{OP_MUL,   C_FULL,    ST_FULL,  ST_DIV1};
			ST_DIV1:  w = '{OP_DIV,   C_CNT,     ST_DIV1,  ST_SAT};
			ST_SAT:   w = '{OP_SAT,   C_ALWAYS,  ST_SRCH,  ST_SRCH};
			ST_SRCH:  w = '{OP_SRCH,  C_SRCH,    ST_SRCH,  ST_CLASS};
			ST_CLASS: w = '{OP_CLASS, C_EDGE,    ST_OUT,   ST_PREP};
			ST_PREP:  w = '{OP_PREP,  C_ALWAYS,  ST_DIV2,  ST_DIV2};
			ST_DIV2:  w = '{OP_DIV,   C_CNT,     ST_DIV2,  ST_FIN};
			ST_FIN:   w = '{OP_FIN,   C_ALWAYS,  ST_OUT,   ST_OUT};
			ST_OUT:   w = '{OP_OUT,   C_OUTBUSY, ST_OUT,   ST_IDLE};
			ST_FULL:  w = '{OP_FULL,  C_ALWAYS,  ST_OUT,   ST_OUT};
			default:  w = '{OP_LOAD,  C_ALWAYS,  ST_IDLE,  ST_IDLE};
		endcase
		return w;
	endfunction

	logic [PC_W-1:0] pc_q;
	ucode_t          word;
	logic            take;

	assign word = prog_word(pc_q);

	// branch condition select
	always_comb begin
		unique case (word.cond)
			C_ALWAYS:  take = 1'b1;
			C_NOIN:    take = !in_valid;
			C_FULL:    take = dp_stat.adc_full;
			C_CNT:     take = dp_stat.cnt_nz;
			C_SRCH:    take = dp_stat.srch_more;
			C_EDGE:    take = dp_stat.at_edge;
			C_OUTBUSY: take = out_busy;
			default:   take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= take ? word.jmp : word.nxt;
		end
	end

	// decoded strobes
	always_comb begin
		ctrl.op        = word.op;
		ctrl.in_ready  = (word.op == OP_LOAD);
		ctrl.in_accept = (word.op == OP_LOAD) && in_valid;
		ctrl.out_load  = (word.op == OP_OUT) && !out_busy;
	end

endmodule

@@ src/ntc_dp.sv @@
// datapath: multiplier, shared restoring divider, table search and interpolation
module ntc_dp import ntc_pkg::*; #(
	parameter int ADC_BITS      = 12,
	parameter int TABLE_ENTRIES = 39
) (
	input  logic                     clk,
	input  ctrl_t                    ctrl,
	input  logic [SER_W-1:0]         series_ohms,
	input  logic [ADC_W-1:0]         adc_sample,
	output dp_stat_t                 dp_stat,
	output logic signed [TEMP_W-1:0] temp_q8,
	output logic [RES_W-1:0]         resistance_tenths,
	output logic [FLAG_W-1:0]        range_flag
);

	localparam int SRCH_N = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
		((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] N_IDX    = IDX_W'(SRCH_N);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SRCH_N - 1);
	localparam logic signed [TEMP_W-1:0] END_T = temp_q8_at(LAST_IDX);
	localparam int CMP_W = (ADC_BITS > ADC_W) ? ADC_BITS : ADC_W;
	localparam logic [CMP_W-1:0] FULL = CMP_W'((64'd1 << ADC_BITS) - 64'd1);

	logic [ADC_W-1:0]         adc_q;
	logic [DIVIDEND_W-1:0]    shreg_q;
	logic [REM_W-1:0]         rem_q;
	logic [DIVISOR_W-1:0]     div_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [RES_W-1:0]         rsat_q;
	logic [IDX_W-1:0]         lo_q;
	logic [IDX_W-1:0]         hi_q;
	logic [RES_W-1:0]         diff_q;
	logic [RES_W-1:0]         den_q;
	logic signed [TEMP_W-1:0] base_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [FLAG_W-1:0]        flag_q;

	logic [SCALED_W-1:0]   s10;
	logic [DIVIDEND_W-1:0] prod;
	logic [CMP_W-1:0]      denom;
	logic [REM_W-1:0]      rem_sh;
	logic                  fits;
	logic [REM_W-1:0]      rem_nx;
	logic [RES_W-1:0]      q_sat;
	logic [IDX_W:0]        mid_sum;
	logic [IDX_W-1:0]      mid;
	logic [RES_W-1:0]      rom_mid;
	logic [RES_W-1:0]      rom_i;
	logic [RES_W-1:0]      rom_prev;
	logic [IDX_W-1:0]      prev_idx;
	logic [INTERP_W-1:0]   dividend2;

	// ten times the series resistor, then times the sample
	assign s10   = SCALED_W'({series_ohms, 3'b0}) + SCALED_W'({series_ohms, 1'b0});
	assign prod  = DIVIDEND_W'(s10) * DIVIDEND_W'(adc_q);
	assign denom = FULL - CMP_W'(adc_q);

	// one restoring divide step, quotient bit shifts into the low end
	assign rem_sh = {rem_q[REM_W-2:0], shreg_q[DIVIDEND_W-1]};
	assign fits   = (rem_sh >= {1'b0, div_q});
	assign rem_nx = fits ? (rem_sh - {1'b0, div_q}) : rem_sh;

	// saturate the resistance quotient
	assign q_sat = (|shreg_q[DIVIDEND_W-1:RES_W]) ? RES_MAX : shreg_q[RES_W-1:0];

	// binary search probe
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];
	assign rom_mid = ntc_rom(mid);

	// bracketing entries
	assign prev_idx = lo_q - 1'b1;
	assign rom_i    = ntc_rom(lo_q);
	assign rom_prev = ntc_rom(prev_idx);

	// 2*1280*(r - lo) + den, rounding numerator of the interpolation
	assign dividend2 = INTERP_W'({diff_q, 11'b0}) + INTERP_W'({diff_q, 9'b0}) +
		INTERP_W'(den_q);

	// datapath registers per operation
	always_ff @(posedge clk) begin
		if (ctrl.in_accept) begin
			adc_q <= adc_sample;
		end
		unique case (ctrl.op)
			OP_MUL: begin
				shreg_q <= prod;
				rem_q   <= '0;
				div_q   <= DIVISOR_W'(denom);
				cnt_q   <= CNT_W'(DIV1_STEPS - 1);
			end
			OP_DIV: begin
				rem_q   <= rem_nx;
				shreg_q <= {shreg_q[DIVIDEND_W-2:0], fits};
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			OP_SAT: begin
				rsat_q <= q_sat;
				lo_q   <= '0;
				hi_q   <= N_IDX;
			end
			OP_SRCH: begin
				if (lo_q < hi_q) begin
					if (rom_mid < rsat_q) begin
						lo_q <= mid + 1'b1;
					end else begin
						hi_q <= mid;
					end
				end
			end
			OP_CLASS: begin
				if (lo_q == N_IDX) begin
					temp_q <= END_T;
					flag_q <= FLAG_COLD;
				end else if (lo_q == '0) begin
					temp_q <= TOP_TEMP_Q8;
					flag_q <= (rsat_q == rom_i) ? FLAG_IN : FLAG_HOT;
				end else begin
					diff_q <= rsat_q - rom_prev;
					den_q  <= rom_i - rom_prev;
					base_q <= temp_q8_at(prev_idx);
				end
			end
			OP_PREP: begin
				// upper bits go straight to the remainder, quotient fits in twelve bits
				rem_q   <= REM_W'(dividend2[INTERP_W-1:DIV2_STEPS]);
				shreg_q <= {dividend2[DIV2_STEPS-1:0], {(DIVIDEND_W-DIV2_STEPS){1'b0}}};
				div_q   <= DIVISOR_W'({den_q, 1'b0});
				cnt_q   <= CNT_W'(DIV2_STEPS - 1);
			end
			OP_FIN: begin
				temp_q <= base_q - $signed(TEMP_W'(shreg_q[DIV2_STEPS-1:0]));
				flag_q <= FLAG_IN;
			end
			OP_FULL: begin
				rsat_q <= RES_MAX;
				temp_q <= END_T;
				flag_q <= FLAG_COLD;
			end
			default: begin
			end
		endcase
	end

	// status toward the sequencer
	always_comb begin
		dp_stat.adc_full  = (CMP_W'(adc_q) >= FULL);
		dp_stat.cnt_nz    = (cnt_q != '0);
		dp_stat.srch_more = (lo_q < hi_q);
		dp_stat.at_edge   = (lo_q == N_IDX) || (lo_q == '0);
	end

	assign temp_q8           = temp_q;
	assign resistance_tenths = rsat_q;
	assign range_flag        = flag_q;

endmodule

@@ src/ntc_thermistor_temperature.sv @@
// Sequence: after a sample is accepted, a 36-step resistance pass and a 12-step interpolation
//   pass of the shared restoring divider, with a binary search between them, give an interpolated
//   result; off-table samples skip the interpolation pass, and a full-scale sample skips the divider.
// Flow: one sample at a time; the next request is taken while a result waits, and a stalled
//   result holds the sequencer in its output step.
// Reset: arst_n returns the step counter to idle, clears output valid and sets series_ohms to 10000.
module ntc_thermistor_temperature import ntc_pkg::*; #(
	parameter int ADC_BITS      = 12,
	parameter int TABLE_ENTRIES = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [SER_W-1:0] cfg_wdata,     // series_ohms
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,  // [11:0] adc_sample
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // [16:0] temp_q8, [38:17] resistance_tenths
	output logic [1:0]       m_axis_tuser   // [1:0] range_flag
);

	logic [SER_W-1:0]         series_q;
	logic                     m_valid_q;
	logic signed [TEMP_W-1:0] m_temp_q;
	logic [RES_W-1:0]         m_res_q;
	logic [FLAG_W-1:0]        m_flag_q;

	ctrl_t                    ctrl;
	dp_stat_t                 dp_stat;
	logic                     out_busy;
	logic signed [TEMP_W-1:0] dp_temp;
	logic [RES_W-1:0]         dp_res;
	logic [FLAG_W-1:0]        dp_flag;

	// series resistor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= SER_W'(10000);
		end else if (cfg_we) begin
			series_q <= cfg_wdata;
		end
	end

	assign out_busy = m_valid_q && !m_axis_tready;

	ntc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_busy (out_busy),
		.dp_stat  (dp_stat),
		.ctrl     (ctrl)
	);

	ntc_dp #(
		.ADC_BITS      (ADC_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk               (clk),
		.ctrl              (ctrl),
		.series_ohms       (series_q),
		.adc_sample        (s_axis_tdata[ADC_W-1:0]),
		.dp_stat           (dp_stat),
		.temp_q8           (dp_temp),
		.resistance_tenths (dp_res),
		.range_flag        (dp_flag)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			m_temp_q <= dp_temp;
			m_res_q  <= dp_res;
			m_flag_q <= dp_flag;
		end
	end

	assign s_axis_tready = ctrl.in_ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_res_q, m_temp_q};
	assign m_axis_tuser  = m_flag_q;

endmodule

@@ src/ntc_checker.sv @@
// port-level checker for the thermistor converter, bound to the top level
`include "ntc_thermistor_temperature_defines.svh"

module ntc_checker import ntc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// a stalled result holds
	`NTC_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// one sample at a time: no new request right after one is taken
	`NTC_ASSERT_NXT(a_busy_after_req, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// range flag is one of the three codes
	`NTC_ASSERT_IMP(a_flag_code, clk, arst_n, m_axis_tvalid, (m_axis_tuser == FLAG_IN) || (m_axis_tuser == FLAG_HOT) || (m_axis_tuser == FLAG_COLD))

	// hotter than the table clamps to the top temperature
	`NTC_ASSERT_IMP(a_hot_clamp, clk, arst_n, m_axis_tvalid && (m_axis_tuser == FLAG_HOT), m_axis_tdata[16:0] == TOP_TEMP_Q8)

endmodule

bind ntc_thermistor_temperature ntc_checker u_ntc_checker (.*);
